// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== src/wls_pkg.sv =====
// Types, constants and the sine table function of the wave line step unit.
package wls_pkg;

   localparam int POINTS_PER_TILE = 8;
   localparam int EDGE_MARGIN = 2;
   localparam int FADE_SHIFT = $clog2(POINTS_PER_TILE);
   localparam int FACTOR_W = $clog2(POINTS_PER_TILE + 1);
   localparam int PHASE_STEP = 174;
   localparam int DIV3_RECIP = 21846;
   localparam int MUL_A_W = 20;
   localparam int MUL_B_W = 18;
   localparam int PROD_W = MUL_A_W + MUL_B_W;
   localparam int H_W = 22;
   localparam logic [31:0] HEIGHT_LIMITS_RESET = 32'h7FFF8000;

   typedef enum logic [1:0] {
      OP_RUN = 2'd0,
      OP_SET = 2'd1,
      OP_GET = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      REG_GAINS       = 3'd0,
      REG_LIMITS      = 3'd1,
      REG_WAVE_LEFT1  = 3'd2,
      REG_WAVE_LEFT2  = 3'd3,
      REG_WAVE_STILL1 = 3'd4,
      REG_WAVE_STILL2 = 3'd5,
      REG_WAVE_RIGHT1 = 3'd6,
      REG_WAVE_RIGHT2 = 3'd7
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE,
      ST_G0, ST_G1, ST_G2, ST_G3, ST_G4, ST_G5, ST_G6,
      ST_STEP, ST_STEND, ST_W0, ST_W1, ST_W2,
      ST_RD, ST_VEL, ST_ADDG, ST_MULK, ST_KR,
      ST_PH, ST_OFF, ST_ANG, ST_IDX, ST_SIN, ST_AMP, ST_ADDW,
      ST_CLAMP, ST_FH, ST_FP, ST_FW, ST_WR
   } state_type;

   // Quarter-wave polynomial sine of an angle in turns, signed Q1.14.
   function automatic logic signed [15:0] sine_of_turns(input logic [15:0] u);
      logic [31:0] x;
      logic [31:0] x2;
      logic [31:0] t;
      logic [31:0] s;
      x = {18'd0, u[13:0]};
      if (u[14]) begin
         x = 32'd16384 - x;
      end
      x2 = (x * x) >> 14;
      t = (32'd1231 * x2) >> 14;
      t = 32'd10583 - t;
      t = (t * x2) >> 14;
      t = 32'd25736 - t;
      s = (x * t) >> 14;
      if (s > 32'd16384) begin
         s = 32'd16384;
      end
      return u[15] ? -signed'(16'(s)) : signed'(16'(s));
   endfunction

endpackage

// ===== src/wave_line_simulation_step_unit.sv =====
// Top level of the damped wave line step unit: sequencer, stores and registers.
//
// A word is taken when start is high and busy is low; its result appears on the
// rsp_ ports for one cycle with rsp_valid high and cannot be held off. After
// reset the unit clears both height stores, one point per cycle, and holds busy
// high until it is done. A set word, a run word with a zero step count, an
// unknown word and a get word out of range answer in the next cycle; any other
// get word answers after the states G0 to G6. A run word first zeroes the points
// dropped by a smaller line size, one per cycle, then runs its steps, in which
// every inner point passes twelve times through the one shared multiplier.
module wave_line_simulation_step_unit #(
   parameter int MAX_POINTS = 256,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [3:0]         req_step_count,
   input  logic [8:0]         req_line_size,
   input  logic [7:0]         req_left_region_end,
   input  logic [7:0]         req_right_region_start,
   input  logic               req_fade_left,
   input  logic               req_fade_right,
   input  logic [7:0]         req_point_index,
   input  logic signed [15:0] req_height_value,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_height_out,
   output logic               rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int SW = $clog2(MAX_POINTS + 1);
   localparam int CW = SW + 10;
   localparam int KW = $clog2(SINE_TABLE_DEPTH);
   localparam int FW = wls_pkg::FACTOR_W;
   localparam int HW = wls_pkg::H_W;
   localparam int AWM = wls_pkg::MUL_A_W;
   localparam int BWM = wls_pkg::MUL_B_W;
   localparam int PPT = wls_pkg::POINTS_PER_TILE;
   localparam int EM = wls_pkg::EDGE_MARGIN;
   localparam int FS = wls_pkg::FADE_SHIFT;

   wls_pkg::state_type state_ff, state_in;
   logic               sel_ff, sel_in;
   logic [15:0]        phase_ff, phase_in;
   logic [SW-1:0]      size_ff, size_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic [SW-1:0]      clr_ptr_ff, clr_ptr_in;
   logic [SW-1:0]      clr_end_ff, clr_end_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [7:0]         lend_ff, lend_in;
   logic [7:0]         rstart_ff, rstart_in;
   logic               fl_ff, fl_in;
   logic               fr_ff, fr_in;
   logic [7:0]         idx_ff, idx_in;
   logic [AW-1:0]      i_ff, i_in;
   logic               w_ff, w_in;
   logic               side_ff, side_in;
   logic signed [15:0] pm1_ff, pm1_in;
   logic signed [15:0] p0_ff, p0_in;
   logic signed [15:0] pn_ff, pn_in;
   logic signed [15:0] pc_ff, pc_in;
   logic signed [HW-1:0] h_ff, h_in;
   logic [15:0]        off_ff, off_in;
   logic [15:0]        ang_ff, ang_in;
   logic [KW-1:0]      k_ff, k_in;
   logic signed [15:0] sin_ff, sin_in;
   logic signed [17:0] sum_ff, sum_in;
   logic signed [17:0] q_ff, q_in;
   logic signed [15:0] rsp_height_ff, rsp_height_in;
   logic               rsp_status_ff, rsp_status_in;

   logic [31:0]        gains_ff;
   logic [31:0]        limits_ff;
   logic [47:0]        wave_ff [6];

   logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

   logic               c_we, p_we;
   logic [AW-1:0]      c_waddr, p_waddr, c_raddr, p_raddr;
   logic signed [15:0] c_wdata, p_wdata, c_rd, p_rd;
   logic               we0, we1;
   logic [AW-1:0]      waddr0, waddr1, raddr0, raddr1;
   logic signed [15:0] wdata0, wdata1, rd0, rd1;

   logic signed [AWM-1:0] mul_a;
   logic signed [BWM-1:0] mul_b;
   logic signed [wls_pkg::PROD_W-1:0] prod_q;

   logic               accept;
   logic signed [CW-1:0] n_s, i_s, idx_s, slope_s, req_idx_s, line_s;
   logic [FW-1:0]      fl_fac, fr_fac, fac;
   logic [2:0]         wsel;
   logic [47:0]        wave_sel;
   logic signed [HW-1:0] lo_h, hi_h;
   logic signed [16:0] pair_sum;
   logic signed [19:0] rem;
   logic signed [17:0] q_fix;
   logic               set_bad;
   logic [SW-1:0]      new_size;

   for (genvar gk = 0; gk < SINE_TABLE_DEPTH; gk++) begin : g_rom
      localparam logic [15:0] TURN = 16'((gk * 65536) / SINE_TABLE_DEPTH);
      assign sine_rom[gk] = wls_pkg::sine_of_turns(TURN);
   end

   function automatic logic signed [HW-1:0] clamp_h(input logic signed [HW-1:0] v,
                                                    input logic signed [HW-1:0] lo,
                                                    input logic signed [HW-1:0] hi);
      logic signed [HW-1:0] t;
      t = v;
      if (t < lo) begin
         t = lo;
      end
      if (t > hi) begin
         t = hi;
      end
      return t;
   endfunction

   wls_bank #(.DEPTH(MAX_POINTS), .ADDR_W(AW)) u_bank0 (
      .clock(clock), .we(we0), .waddr(waddr0), .wdata(wdata0),
      .raddr(raddr0), .rdata(rd0)
   );

   wls_bank #(.DEPTH(MAX_POINTS), .ADDR_W(AW)) u_bank1 (
      .clock(clock), .we(we1), .waddr(waddr1), .wdata(wdata1),
      .raddr(raddr1), .rdata(rd1)
   );

   wls_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .prod(prod_q));

   // The current store lives in the bank named by sel; the other is previous.
   assign we0    = sel_ff ? p_we : c_we;
   assign waddr0 = sel_ff ? p_waddr : c_waddr;
   assign wdata0 = sel_ff ? p_wdata : c_wdata;
   assign raddr0 = sel_ff ? p_raddr : c_raddr;
   assign we1    = sel_ff ? c_we : p_we;
   assign waddr1 = sel_ff ? c_waddr : p_waddr;
   assign wdata1 = sel_ff ? c_wdata : p_wdata;
   assign raddr1 = sel_ff ? c_raddr : p_raddr;
   assign c_rd   = sel_ff ? rd1 : rd0;
   assign p_rd   = sel_ff ? rd0 : rd1;

   assign busy      = (state_ff != wls_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign n_s       = signed'(CW'(size_ff));
   assign i_s       = signed'(CW'(i_ff));
   assign idx_s     = signed'(CW'(idx_ff));
   assign req_idx_s = signed'(CW'(req_point_index));
   assign line_s    = signed'(CW'(req_line_size));
   assign slope_s   = n_s - CW'(PPT + EM);
   assign new_size  = (line_s > CW'(MAX_POINTS)) ? SW'(MAX_POINTS) : SW'(req_line_size);
   assign set_bad   = (req_idx_s >= n_s - CW'(2 * EM + 1)) || (req_idx_s <= CW'(1 + EM))
                      || (req_idx_s >= CW'(MAX_POINTS));

   assign lo_h = HW'(signed'(limits_ff[15:0]));
   assign hi_h = HW'(signed'(limits_ff[31:16]));
   assign pair_sum = 17'(pm1_ff) + 17'(p_rd);

   always_comb begin
      if (!fl_ff) begin
         fl_fac = FW'(PPT);
      end else if (i_s < CW'(EM)) begin
         fl_fac = '0;
      end else if (i_s <= CW'(PPT + EM)) begin
         fl_fac = FW'(i_s - CW'(EM));
      end else begin
         fl_fac = FW'(PPT);
      end
      if (!fr_ff) begin
         fr_fac = FW'(PPT);
      end else if (i_s > slope_s + CW'(PPT)) begin
         fr_fac = '0;
      end else if (i_s >= slope_s) begin
         fr_fac = FW'(slope_s + CW'(PPT) - i_s);
      end else begin
         fr_fac = FW'(PPT);
      end
      fac = side_ff ? fr_fac : fl_fac;
      if (i_s < signed'(CW'(lend_ff))) begin
         wsel = {2'd0, w_ff};
      end else if (i_s > signed'(CW'(rstart_ff))) begin
         wsel = {2'd2, w_ff};
      end else begin
         wsel = {2'd1, w_ff};
      end
      wave_sel = wave_ff[wsel];
   end

   always_comb begin
      rem = 20'(sum_ff) - (20'(q_ff) <<< 1) - 20'(q_ff);
      if (rem < 20'sd0) begin
         q_fix = q_ff - 18'sd1;
      end else if (rem >= 20'sd3) begin
         q_fix = q_ff + 18'sd1;
      end else begin
         q_fix = q_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      phase_in = phase_ff;
      size_in = size_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      clr_ptr_in = clr_ptr_ff;
      clr_end_in = clr_end_ff;
      rsp_valid_in = 1'b0;
      rsp_height_in = rsp_height_ff;
      rsp_status_in = rsp_status_ff;
      lend_in = lend_ff;
      rstart_in = rstart_ff;
      fl_in = fl_ff;
      fr_in = fr_ff;
      idx_in = idx_ff;
      i_in = i_ff;
      w_in = w_ff;
      side_in = side_ff;
      pm1_in = pm1_ff;
      p0_in = p0_ff;
      pn_in = pn_ff;
      pc_in = pc_ff;
      h_in = h_ff;
      off_in = off_ff;
      ang_in = ang_ff;
      k_in = k_ff;
      sin_in = sin_ff;
      sum_in = sum_ff;
      q_in = q_ff;
      c_we = 1'b0;
      p_we = 1'b0;
      c_waddr = i_ff;
      p_waddr = i_ff;
      c_wdata = 16'(h_ff);
      p_wdata = pc_ff;
      c_raddr = i_ff;
      p_raddr = i_ff + AW'(1);
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         wls_pkg::ST_CLEAR: begin
            if (clr_ptr_ff < clr_end_ff) begin
               c_we = 1'b1;
               p_we = 1'b1;
               c_waddr = AW'(clr_ptr_ff);
               p_waddr = AW'(clr_ptr_ff);
               c_wdata = '0;
               p_wdata = '0;
               clr_ptr_in = clr_ptr_ff + SW'(1);
            end else begin
               state_in = run_ff ? wls_pkg::ST_STEP : wls_pkg::ST_IDLE;
            end
         end
         wls_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  wls_pkg::OP_RUN: begin
                     if (req_step_count != 4'd0) begin
                        size_in = new_size;
                        clr_ptr_in = new_size;
                        clr_end_in = size_ff;
                        run_in = 1'b1;
                        cnt_in = req_step_count;
                        lend_in = req_left_region_end;
                        rstart_in = req_right_region_start;
                        fl_in = req_fade_left;
                        fr_in = req_fade_right;
                        state_in = wls_pkg::ST_CLEAR;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_height_in = '0;
                        rsp_status_in = 1'b0;
                     end
                  end
                  wls_pkg::OP_SET: begin
                     if (!set_bad) begin
                        p_we = 1'b1;
                        p_waddr = AW'(req_point_index);
                        p_wdata = req_height_value;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_height_in = '0;
                     rsp_status_in = set_bad;
                  end
                  wls_pkg::OP_GET: begin
                     if ((req_idx_s >= n_s) || (req_idx_s >= CW'(MAX_POINTS))) begin
                        rsp_valid_in = 1'b1;
                        rsp_height_in = '0;
                        rsp_status_in = 1'b1;
                     end else begin
                        idx_in = req_point_index;
                        state_in = wls_pkg::ST_G0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_height_in = '0;
                     rsp_status_in = 1'b1;
                  end
               endcase
            end
         end
         wls_pkg::ST_G0: begin
            c_raddr = AW'(idx_ff);
            state_in = wls_pkg::ST_G1;
         end
         wls_pkg::ST_G1: begin
            sum_in = 18'(c_rd);
            c_raddr = AW'({1'b0, idx_ff} + 9'd1);
            state_in = wls_pkg::ST_G2;
         end
         wls_pkg::ST_G2: begin
            if (idx_s + CW'(1) < n_s) begin
               sum_in = sum_ff + 18'(c_rd);
            end
            c_raddr = AW'(idx_ff - 8'd1);
            state_in = wls_pkg::ST_G3;
         end
         wls_pkg::ST_G3: begin
            if (idx_ff != 8'd0) begin
               sum_in = sum_ff + 18'(c_rd);
            end
            state_in = wls_pkg::ST_G4;
         end
         wls_pkg::ST_G4: begin
            mul_a = AWM'(sum_ff);
            mul_b = BWM'(wls_pkg::DIV3_RECIP);
            state_in = wls_pkg::ST_G5;
         end
         wls_pkg::ST_G5: begin
            q_in = 18'(prod_q >>> 16);
            state_in = wls_pkg::ST_G6;
         end
         wls_pkg::ST_G6: begin
            rsp_valid_in = 1'b1;
            rsp_height_in = 16'(q_fix);
            rsp_status_in = 1'b0;
            state_in = wls_pkg::ST_IDLE;
         end
         wls_pkg::ST_STEP: begin
            phase_in = phase_ff + 16'(wls_pkg::PHASE_STEP);
            sel_in = ~sel_ff;
            cnt_in = cnt_ff - 4'd1;
            state_in = (size_ff >= SW'(3)) ? wls_pkg::ST_W0 : wls_pkg::ST_STEND;
         end
         wls_pkg::ST_STEND: begin
            if (cnt_ff == 4'd0) begin
               run_in = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_height_in = '0;
               rsp_status_in = 1'b0;
               state_in = wls_pkg::ST_IDLE;
            end else begin
               state_in = wls_pkg::ST_STEP;
            end
         end
         wls_pkg::ST_W0: begin
            p_raddr = '0;
            state_in = wls_pkg::ST_W1;
         end
         wls_pkg::ST_W1: begin
            pm1_in = p_rd;
            p_raddr = AW'(1);
            state_in = wls_pkg::ST_W2;
         end
         wls_pkg::ST_W2: begin
            p0_in = p_rd;
            i_in = AW'(1);
            state_in = wls_pkg::ST_RD;
         end
         wls_pkg::ST_RD: begin
            state_in = wls_pkg::ST_VEL;
         end
         wls_pkg::ST_VEL: begin
            pn_in = p_rd;
            h_in = HW'(pair_sum >>> 1);
            mul_a = AWM'(p0_ff) - AWM'(c_rd);
            mul_b = BWM'(signed'(gains_ff[15:0]));
            state_in = wls_pkg::ST_ADDG;
         end
         wls_pkg::ST_ADDG: begin
            h_in = h_ff + HW'(prod_q >>> 14);
            state_in = wls_pkg::ST_MULK;
         end
         wls_pkg::ST_MULK: begin
            mul_a = AWM'(h_ff);
            mul_b = BWM'(signed'(gains_ff[31:16]));
            state_in = wls_pkg::ST_KR;
         end
         wls_pkg::ST_KR: begin
            h_in = HW'(prod_q >>> 14);
            w_in = 1'b0;
            state_in = wls_pkg::ST_PH;
         end
         wls_pkg::ST_PH: begin
            mul_a = AWM'(signed'({1'b0, phase_ff}));
            mul_b = BWM'(signed'(wave_sel[15:0]));
            state_in = wls_pkg::ST_OFF;
         end
         wls_pkg::ST_OFF: begin
            off_in = prod_q[23:8];
            mul_a = AWM'(signed'({1'b0, i_ff}));
            mul_b = BWM'(signed'({1'b0, wave_sel[31:16]}));
            state_in = wls_pkg::ST_ANG;
         end
         wls_pkg::ST_ANG: begin
            ang_in = prod_q[15:0] + off_ff;
            state_in = wls_pkg::ST_IDX;
         end
         wls_pkg::ST_IDX: begin
            k_in = KW'((32'(ang_ff) * 32'(SINE_TABLE_DEPTH)) >> 16);
            state_in = wls_pkg::ST_SIN;
         end
         wls_pkg::ST_SIN: begin
            sin_in = sine_rom[k_ff];
            state_in = wls_pkg::ST_AMP;
         end
         wls_pkg::ST_AMP: begin
            mul_a = AWM'(sin_ff);
            mul_b = BWM'(signed'(wave_sel[47:32]));
            state_in = wls_pkg::ST_ADDW;
         end
         wls_pkg::ST_ADDW: begin
            h_in = h_ff + HW'(prod_q >>> 14);
            if (!w_ff) begin
               w_in = 1'b1;
               state_in = wls_pkg::ST_PH;
            end else begin
               state_in = wls_pkg::ST_CLAMP;
            end
         end
         wls_pkg::ST_CLAMP: begin
            h_in = clamp_h(h_ff, lo_h, hi_h);
            pc_in = 16'(clamp_h(HW'(p0_ff), lo_h, hi_h));
            side_in = 1'b0;
            state_in = wls_pkg::ST_FH;
         end
         wls_pkg::ST_FH: begin
            mul_a = AWM'(h_ff);
            mul_b = BWM'(signed'({1'b0, fac}));
            state_in = wls_pkg::ST_FP;
         end
         wls_pkg::ST_FP: begin
            h_in = HW'(prod_q >>> FS);
            mul_a = AWM'(pc_ff);
            mul_b = BWM'(signed'({1'b0, fac}));
            state_in = wls_pkg::ST_FW;
         end
         wls_pkg::ST_FW: begin
            pc_in = 16'(prod_q >>> FS);
            if (!side_ff) begin
               side_in = 1'b1;
               state_in = wls_pkg::ST_FH;
            end else begin
               state_in = wls_pkg::ST_WR;
            end
         end
         wls_pkg::ST_WR: begin
            c_we = 1'b1;
            p_we = 1'b1;
            pm1_in = pc_ff;
            p0_in = pn_ff;
            if (i_s + CW'(2) < n_s) begin
               i_in = i_ff + AW'(1);
               state_in = wls_pkg::ST_RD;
            end else begin
               state_in = wls_pkg::ST_STEND;
            end
         end
         default: begin
            state_in = wls_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wls_pkg::ST_CLEAR;
         sel_ff <= 1'b0;
         phase_ff <= '0;
         size_ff <= '0;
         cnt_ff <= '0;
         run_ff <= 1'b0;
         clr_ptr_ff <= '0;
         clr_end_ff <= SW'(MAX_POINTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
         phase_ff <= phase_in;
         size_ff <= size_in;
         cnt_ff <= cnt_in;
         run_ff <= run_in;
         clr_ptr_ff <= clr_ptr_in;
         clr_end_ff <= clr_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lend_ff <= lend_in;
      rstart_ff <= rstart_in;
      fl_ff <= fl_in;
      fr_ff <= fr_in;
      idx_ff <= idx_in;
      i_ff <= i_in;
      w_ff <= w_in;
      side_ff <= side_in;
      pm1_ff <= pm1_in;
      p0_ff <= p0_in;
      pn_ff <= pn_in;
      pc_ff <= pc_in;
      h_ff <= h_in;
      off_ff <= off_in;
      ang_ff <= ang_in;
      k_ff <= k_in;
      sin_ff <= sin_in;
      sum_ff <= sum_in;
      q_ff <= q_in;
      rsp_height_ff <= rsp_height_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
         limits_ff <= wls_pkg::HEIGHT_LIMITS_RESET;
         for (int r = 0; r < 6; r++) begin
            wave_ff[r] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            wls_pkg::REG_GAINS:       gains_ff <= csr_data[31:0];
            wls_pkg::REG_LIMITS:      limits_ff <= csr_data[31:0];
            wls_pkg::REG_WAVE_LEFT1:  wave_ff[0] <= csr_data;
            wls_pkg::REG_WAVE_LEFT2:  wave_ff[1] <= csr_data;
            wls_pkg::REG_WAVE_STILL1: wave_ff[2] <= csr_data;
            wls_pkg::REG_WAVE_STILL2: wave_ff[3] <= csr_data;
            wls_pkg::REG_WAVE_RIGHT1: wave_ff[4] <= csr_data;
            wls_pkg::REG_WAVE_RIGHT2: wave_ff[5] <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_height_out = rsp_height_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== src/wls_bank.sv =====
// One height store with a write port and a registered read port.
module wls_bank #(
   parameter int DEPTH = 256,
   parameter int ADDR_W = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [ADDR_W-1:0]        waddr,
   input  logic signed [15:0]       wdata,
   input  logic [ADDR_W-1:0]        raddr,
   output logic signed [15:0]       rdata
);

   logic signed [15:0] store_ff [DEPTH];
   logic signed [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/wls_mul.sv =====
// Shared signed multiplier with a registered product.
module wls_mul (
   input  logic                                  clock,
   input  logic signed [wls_pkg::MUL_A_W-1:0]    a,
   input  logic signed [wls_pkg::MUL_B_W-1:0]    b,
   output logic signed [wls_pkg::PROD_W-1:0]     prod
);

   logic signed [wls_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= wls_pkg::PROD_W'(a) * wls_pkg::PROD_W'(b);
   end

   assign prod = prod_ff;

endmodule

// ===== src/wls_checker.sv =====
// Port-level checks of the wave line step unit and their binding.
`include "assert_macros.svh"

module wls_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [1:0]         req_opcode,
   input logic [3:0]         req_step_count,
   input logic               rsp_valid,
   input logic signed [15:0] rsp_height_out,
   input logic               rsp_status
);

   `ASSERT_NEXT(a_run_busy, clock, reset, start && !busy && req_opcode == wls_pkg::OP_RUN && req_step_count != 4'd0, busy)
   `ASSERT_NEXT(a_set_answer, clock, reset, start && !busy && req_opcode == wls_pkg::OP_SET, rsp_valid && !busy)
   `ASSERT_NEXT(a_get_busy, clock, reset, start && !busy && req_opcode == wls_pkg::OP_GET, busy || (rsp_valid && rsp_status))
   `ASSERT_IMPLY(a_reject_zero, clock, reset, rsp_valid && rsp_status, rsp_height_out == 16'sd0)

endmodule

bind wave_line_simulation_step_unit wls_checker u_wls_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_opcode(req_opcode),
   .req_step_count(req_step_count),
   .rsp_valid(rsp_valid),
   .rsp_height_out(rsp_height_out),
   .rsp_status(rsp_status)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the wave line step unit with a predicting scoreboard.
module testbench;

   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam int LINE_DEPTH = 256;
   localparam int STALL_LIMIT = 400000;

   typedef struct {
      logic [1:0]         opcode;
      logic [3:0]         step_count;
      logic [8:0]         line_size;
      logic [7:0]         left_region_end;
      logic [7:0]         right_region_start;
      logic               fade_left;
      logic               fade_right;
      logic [7:0]         point_index;
      logic signed [15:0] height_value;
   } word_type;

   typedef struct {
      logic signed [15:0] height_out;
      logic               status;
   } answer_type;

   class wave_line_scoreboard;
      logic signed [15:0] cur_heights[LINE_DEPTH];
      logic signed [15:0] prev_heights[LINE_DEPTH];
      longint             phase;
      longint             size;
      logic [47:0]        regs[8];
      answer_type         expected_answers[$];
      int                 errors;

      function new();
         foreach (cur_heights[i]) begin
            cur_heights[i] = '0;
            prev_heights[i] = '0;
         end
         foreach (regs[i]) begin
            regs[i] = '0;
         end
         regs[wls_pkg::REG_LIMITS] = {16'd0, wls_pkg::HEIGHT_LIMITS_RESET};
         phase = 0;
         size = 0;
         errors = 0;
      endfunction

      function void write_reg(wls_pkg::reg_index_type idx, logic [47:0] value);
         regs[idx] = (idx == wls_pkg::REG_GAINS || idx == wls_pkg::REG_LIMITS)
                     ? {16'd0, value[31:0]} : value;
      endfunction

      function longint table_sine(longint angle);
         longint k;
         longint u;
         longint q;
         longint x;
         longint x2;
         longint t;
         longint s;
         k = (angle * LINE_DEPTH) >> 16;
         u = (k * 65536) / LINE_DEPTH;
         q = (u >> 14) & 3;
         x = u & 16'h3FFF;
         if (q[0]) begin
            x = 16384 - x;
         end
         x2 = (x * x) >> 14;
         t = (1231 * x2) >> 14;
         t = 10583 - t;
         t = (t * x2) >> 14;
         t = 25736 - t;
         s = (x * t) >> 14;
         if (s > 16384) begin
            s = 16384;
         end
         return (q >= 2) ? -s : s;
      endfunction

      function longint ripple(logic [47:0] r, longint i);
         longint speed;
         longint width;
         longint amp;
         longint offset;
         longint angle;
         speed = longint'($signed(r[15:0]));
         width = longint'(r[31:16]);
         amp = longint'($signed(r[47:32]));
         offset = (phase * speed) >>> 8;
         angle = (i * width + offset) & 65535;
         return (table_sine(angle) * amp) >>> 14;
      endfunction

      function longint limit(longint v, longint lo, longint hi);
         if (v < lo) begin
            v = lo;
         end
         if (v > hi) begin
            v = hi;
         end
         return v;
      endfunction

      function void advance(word_type w);
         logic signed [15:0] swap;
         longint g;
         longint kd;
         longint lo;
         longint hi;
         longint slope;
         longint vel;
         longint h;
         longint p;
         int     base;
         phase = (phase + wls_pkg::PHASE_STEP) & 65535;
         for (int j = 0; j < LINE_DEPTH; j++) begin
            swap = cur_heights[j];
            cur_heights[j] = prev_heights[j];
            prev_heights[j] = swap;
         end
         g = longint'($signed(regs[wls_pkg::REG_GAINS][15:0]));
         kd = longint'($signed(regs[wls_pkg::REG_GAINS][31:16]));
         lo = longint'($signed(regs[wls_pkg::REG_LIMITS][15:0]));
         hi = longint'($signed(regs[wls_pkg::REG_LIMITS][31:16]));
         slope = size - wls_pkg::POINTS_PER_TILE - wls_pkg::EDGE_MARGIN;
         for (longint i = 1; i + 1 < size; i++) begin
            vel = longint'(prev_heights[i]) - longint'(cur_heights[i]);
            h = (longint'(prev_heights[i - 1]) + longint'(prev_heights[i + 1])) >>> 1;
            h = h + ((vel * g) >>> 14);
            h = (h * kd) >>> 14;
            if (i < longint'(w.left_region_end)) begin
               base = wls_pkg::REG_WAVE_LEFT1;
            end else if (i > longint'(w.right_region_start)) begin
               base = wls_pkg::REG_WAVE_RIGHT1;
            end else begin
               base = wls_pkg::REG_WAVE_STILL1;
            end
            h = h + ripple(regs[base], i) + ripple(regs[base + 1], i);
            h = limit(h, lo, hi);
            p = limit(longint'(prev_heights[i]), lo, hi);
            if (w.fade_left) begin
               if (i < wls_pkg::EDGE_MARGIN) begin
                  h = 0;
                  p = 0;
               end else if (i <= wls_pkg::POINTS_PER_TILE + wls_pkg::EDGE_MARGIN) begin
                  h = (h * (i - wls_pkg::EDGE_MARGIN)) >>> wls_pkg::FADE_SHIFT;
                  p = (p * (i - wls_pkg::EDGE_MARGIN)) >>> wls_pkg::FADE_SHIFT;
               end
            end
            if (w.fade_right) begin
               if (i > slope + wls_pkg::POINTS_PER_TILE) begin
                  h = 0;
                  p = 0;
               end else if (i >= slope) begin
                  h = (h * (slope + wls_pkg::POINTS_PER_TILE - i)) >>> wls_pkg::FADE_SHIFT;
                  p = (p * (slope + wls_pkg::POINTS_PER_TILE - i)) >>> wls_pkg::FADE_SHIFT;
               end
            end
            cur_heights[i] = 16'(h);
            prev_heights[i] = 16'(p);
         end
      endfunction

      function void note_word(word_type w);
         answer_type a;
         longint idx;
         longint sum;
         longint new_size;
         a.height_out = '0;
         a.status = 1'b0;
         idx = longint'(w.point_index);
         if (w.opcode == wls_pkg::OP_RUN) begin
            if (w.step_count != 0) begin
               new_size = (w.line_size > LINE_DEPTH) ? LINE_DEPTH : longint'(w.line_size);
               for (longint j = new_size; j < size; j++) begin
                  cur_heights[j] = '0;
                  prev_heights[j] = '0;
               end
               size = new_size;
               for (int c = 0; c < w.step_count; c++) begin
                  advance(w);
               end
            end
         end else if (w.opcode == wls_pkg::OP_SET) begin
            if (idx >= size - 1 - 2 * wls_pkg::EDGE_MARGIN || idx <= 1 + wls_pkg::EDGE_MARGIN)
            begin
               a.status = 1'b1;
            end else begin
               prev_heights[idx] = w.height_value;
            end
         end else if (w.opcode == wls_pkg::OP_GET) begin
            if (idx >= size) begin
               a.status = 1'b1;
            end else begin
               sum = longint'(cur_heights[idx]);
               if (idx + 1 < size) begin
                  sum = sum + longint'(cur_heights[idx + 1]);
               end
               if (idx > 0) begin
                  sum = sum + longint'(cur_heights[idx - 1]);
               end
               sum = (sum >= 0) ? sum / 3 : -((-sum + 2) / 3);
               a.height_out = 16'(sum);
            end
         end else begin
            a.status = 1'b1;
         end
         expected_answers = {expected_answers, a};
      endfunction

      function void check_word(logic signed [15:0] height_out, logic status);
         answer_type a;
         if (expected_answers.size() == 0) begin
            $error("unexpected result word: height_out %0d status %0d", height_out, status);
            errors++;
            return;
         end
         a = expected_answers.pop_front();
         if (height_out !== a.height_out) begin
            $error("height_out: expected %0d, actual %0d", a.height_out, height_out);
            errors++;
         end
         if (status !== a.status) begin
            $error("status: expected %0d, actual %0d", a.status, status);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_opcode;
   logic [3:0]         req_step_count;
   logic [8:0]         req_line_size;
   logic [7:0]         req_left_region_end;
   logic [7:0]         req_right_region_start;
   logic               req_fade_left;
   logic               req_fade_right;
   logic [7:0]         req_point_index;
   logic signed [15:0] req_height_value;
   logic               rsp_valid;
   logic signed [15:0] rsp_height_out;
   logic               rsp_status;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [47:0]        csr_data;

   wave_line_simulation_step_unit uut (.*);

   wave_line_scoreboard sb = new();
   int sender_idle_pct;
   int stall_cycles;

   initial begin
      clock = 1'b0;
      forever begin
         #4 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            sb.check_word(rsp_height_out, rsp_status);
         end
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   task automatic send_word(word_type w);
      @(negedge clock);
      start = 1'b1;
      req_opcode = w.opcode;
      req_step_count = w.step_count;
      req_line_size = w.line_size;
      req_left_region_end = w.left_region_end;
      req_right_region_start = w.right_region_start;
      req_fade_left = w.fade_left;
      req_fade_right = w.fade_right;
      req_point_index = w.point_index;
      req_height_value = w.height_value;
      do begin
         @(posedge clock);
      end while (busy);
      sb.note_word(w);
      if ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic write_reg(wls_pkg::reg_index_type idx, logic [47:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (sb.expected_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic configure(int mode);
      logic [47:0] value;
      drain();
      for (int r = 0; r < 8; r++) begin
         value = 48'({$urandom(), $urandom()});
         case (mode)
            0: begin
               if (r == wls_pkg::REG_GAINS) value = 48'h0000_3E00_2000;
               else if (r == wls_pkg::REG_LIMITS) value = 48'h0000_7FFF_8000;
               else value = {16'($urandom_range(0, 16'h1800)), value[31:0]};
            end
            1: begin
               value = '1;
            end
            2: begin
               if (r == wls_pkg::REG_LIMITS) value = 48'h0000_8000_7FFF;
               else value = '0;
            end
            3: begin
               if (r == wls_pkg::REG_GAINS) value = 48'h0000_7FFF_7FFF;
               else if (r == wls_pkg::REG_LIMITS) value = 48'h0000_2000_E000;
            end
            default: begin
            end
         endcase
         write_reg(wls_pkg::reg_index_type'(r), value);
      end
   endtask

   function automatic word_type make_word(logic [1:0] op, int steps, int line, int idx,
                                          int hv, bit fl, bit fr);
      word_type w;
      w.opcode = op;
      w.step_count = 4'(steps);
      w.line_size = 9'(line);
      w.left_region_end = 8'($urandom_range(0, 12));
      w.right_region_start = 8'($urandom_range(4, 20));
      w.fade_left = fl;
      w.fade_right = fr;
      w.point_index = 8'(idx);
      w.height_value = 16'(hv);
      return w;
   endfunction

   function automatic word_type random_word();
      word_type w;
      int pick;
      int n;
      pick = $urandom_range(99);
      n = int'(sb.size);
      w = make_word(wls_pkg::OP_RUN, 0, 0, 0, 0, 1'($urandom), 1'($urandom));
      w.height_value = 16'($urandom);
      w.point_index = 8'($urandom);
      if ($urandom_range(3) == 0) begin
         w.left_region_end = 8'($urandom);
         w.right_region_start = 8'($urandom);
      end else begin
         w.left_region_end = 8'($urandom_range(0, 40));
         w.right_region_start = 8'($urandom_range(0, 40));
      end
      if (pick < 33) begin
         w.opcode = wls_pkg::OP_RUN;
         if ($urandom_range(299) == 0) begin
            w.step_count = 4'($urandom_range(1, 2));
            w.line_size = 9'($urandom_range(200, 511));
         end else if ($urandom_range(19) == 0) begin
            w.step_count = 4'($urandom_range(0, 15));
            w.line_size = 9'($urandom_range(0, 14));
         end else begin
            w.step_count = 4'($urandom_range(0, 3));
            w.line_size = 9'($urandom_range(3, 40));
         end
      end else if (pick < 63) begin
         w.opcode = wls_pkg::OP_SET;
         if (n > 10 && $urandom_range(4) != 0) begin
            w.point_index = 8'($urandom_range(4, n - 6));
         end
      end else if (pick < 95) begin
         w.opcode = wls_pkg::OP_GET;
         if (n > 0 && $urandom_range(4) != 0) begin
            w.point_index = 8'($urandom_range(0, n - 1));
         end
      end else begin
         w.opcode = OP_UNKNOWN;
      end
      return w;
   endfunction

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_opcode = wls_pkg::OP_RUN;
      req_step_count = '0;
      req_line_size = '0;
      req_left_region_end = '0;
      req_right_region_start = '0;
      req_fade_left = 1'b0;
      req_fade_right = 1'b0;
      req_point_index = '0;
      req_height_value = '0;
      csr_valid = 1'b0;
      csr_index = wls_pkg::REG_GAINS;
      csr_data = '0;
      sender_idle_pct = 6;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      configure(0);
      send_word(make_word(wls_pkg::OP_GET, 0, 0, 0, 0, 0, 0));
      send_word(make_word(wls_pkg::OP_RUN, 1, 20, 0, 0, 0, 0));
      send_word(make_word(wls_pkg::OP_SET, 0, 0, 4, 32767, 0, 0));
      send_word(make_word(wls_pkg::OP_SET, 0, 0, 14, -32768, 0, 0));
      send_word(make_word(wls_pkg::OP_SET, 0, 0, 3, 100, 0, 0));
      send_word(make_word(wls_pkg::OP_SET, 0, 0, 15, 100, 0, 0));
      send_word(make_word(wls_pkg::OP_SET, 0, 0, 255, -1, 0, 0));
      send_word(make_word(wls_pkg::OP_RUN, 2, 20, 0, 0, 1, 1));
      send_word(make_word(wls_pkg::OP_GET, 0, 0, 0, 0, 0, 0));
      send_word(make_word(wls_pkg::OP_GET, 0, 0, 19, 0, 0, 0));
      send_word(make_word(wls_pkg::OP_GET, 0, 0, 10, 0, 0, 0));
      send_word(make_word(wls_pkg::OP_GET, 0, 0, 20, 0, 0, 0));
      send_word(make_word(wls_pkg::OP_GET, 0, 0, 255, 0, 0, 0));
      send_word(make_word(wls_pkg::OP_RUN, 15, 12, 0, 0, 1, 0));
      send_word(make_word(wls_pkg::OP_RUN, 0, 100, 0, 0, 0, 0));
      send_word(make_word(wls_pkg::OP_RUN, 1, 2, 0, 0, 0, 0));
      send_word(make_word(wls_pkg::OP_RUN, 1, 0, 0, 0, 0, 0));
      send_word(make_word(wls_pkg::OP_RUN, 1, 511, 0, 0, 0, 1));
      send_word(make_word(wls_pkg::OP_SET, 0, 0, 250, 1234, 0, 0));
      send_word(make_word(wls_pkg::OP_GET, 0, 0, 255, 0, 0, 0));
      send_word(make_word(wls_pkg::OP_RUN, 1, 16, 0, 0, 1, 1));
      send_word(make_word(wls_pkg::OP_GET, 0, 0, 15, 0, 0, 0));
      send_word(make_word(OP_UNKNOWN, 0, 0, 0, 0, 0, 0));

      for (int ph = 0; ph < 6; ph++) begin
         configure((ph == 5) ? 4 : ph);
         sender_idle_pct = (ph < 2) ? 6 : (ph < 4) ? 64 : 0;
         for (int k = 0; k < 165; k++) begin
            send_word(random_word());
         end
      end
      drain();
      if (sb.errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ===== wave_line_simulation_step_unit.f =====
+incdir+src
src/wls_pkg.sv
src/wls_bank.sv
src/wls_mul.sv
src/wave_line_simulation_step_unit.sv
src/wls_checker.sv
tb/sv/testbench.sv
